### src/cnd_pkg.sv
// ---------------------------------------------------------------------------
// cnd_pkg
// Shared types and constants for the codebook nibble dot-product block.
// ---------------------------------------------------------------------------
package cnd_pkg;

  localparam int MAX_ELEMENTS_DEF = 2048;   // activation store size (elements)
  localparam int LANES            = 16;     // weight nibbles per item
  localparam int ACT_BYTES        = 8;      // activation bytes per load item
  localparam int PART_GROUPS      = 4;      // partial sums in the adder tree
  localparam int PART_SIZE        = LANES / PART_GROUPS;
  localparam int WORD_W           = 64;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_WEIGHT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_CODEBOOK_LOW  = 2'd0,
    REG_CODEBOOK_HIGH = 2'd1
  } cfg_reg_t;

  typedef logic signed [7:0]  sbyte_t;
  typedef logic signed [15:0] prod_t;
  typedef logic signed [17:0] part_t;
  typedef logic signed [19:0] group_sum_t;

  typedef sbyte_t [LANES-1:0] lane_bytes_t;

  // Control that travels alongside a weight item through the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

### src/cnd_ram.sv
// ---------------------------------------------------------------------------
// cnd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module cnd_ram #(
  parameter int  WIDTH  = 64,
  parameter int  DEPTH  = 128,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/cnd_decode.sv
// ---------------------------------------------------------------------------
// cnd_decode
// Input stage: splits a weight item into nibbles, looks each one up in the
// codebook and flags elements that lie inside the activation store.
// ---------------------------------------------------------------------------
module cnd_decode import cnd_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    weight_valid,
  input  logic                    last_of_row,
  input  logic [7:0]              group,
  input  logic [WORD_W-1:0]       payload,
  input  logic [WORD_W-1:0]       codebook_low,
  input  logic [WORD_W-1:0]       codebook_high,
  output stage_ctl_t              ctl,
  output lane_bytes_t             entries,
  output logic [LANES-1:0]        act_mask
);

  localparam logic [16:0] ElemLimit = 17'(MAX_ELEMENTS);

  lane_bytes_t      entries_next;
  logic [LANES-1:0] mask_next;

  function automatic sbyte_t cb_lookup(input logic [3:0] nib,
                                       input logic [WORD_W-1:0] lo,
                                       input logic [WORD_W-1:0] hi);
    logic [WORD_W-1:0] word;
    word = nib[3] ? hi : lo;
    return sbyte_t'(word[{nib[2:0], 3'b000} +: 8]);
  endfunction

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      // even element in the low nibble, odd element in the high nibble
      entries_next[i] = cb_lookup(payload[8*(i/2) + 4*(i%2) +: 4],
                                  codebook_low, codebook_high);
      mask_next[i]    = {5'b0, group, 4'(i)} < ElemLimit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= weight_valid;
      ctl.last  <= last_of_row;
    end
    entries  <= entries_next;
    act_mask <= mask_next;
  end

endmodule

### src/cnd_mac.sv
// ---------------------------------------------------------------------------
// cnd_mac
// Multiply-accumulate: sixteen 8x8 products, a registered adder tree and the
// 32-bit row accumulator that emits the row sum on the last item of a row.
// ---------------------------------------------------------------------------
module cnd_mac import cnd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  stage_ctl_t             ctl_in,
  input  lane_bytes_t            entries,
  input  logic [LANES-1:0]       act_mask,
  input  logic [WORD_W-1:0]      act_even,
  input  logic [WORD_W-1:0]      act_odd,
  output logic                   done,
  output logic signed [31:0]     row_sum
);

  logic [2*WORD_W-1:0] act_all;
  prod_t               prod_next [LANES];
  prod_t               prod      [LANES];
  part_t               part_next [PART_GROUPS];
  part_t               part      [PART_GROUPS];
  group_sum_t          group_sum;
  logic signed [31:0]  acc;
  logic signed [31:0]  acc_sum;
  stage_ctl_t          ctl_prod;
  stage_ctl_t          ctl_part;

  assign act_all = {act_odd, act_even};

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod_next[i] = $signed(entries[i]) *
                     (act_mask[i] ? $signed(act_all[8*i +: 8]) : 8'sd0);
    end
  end

  always_comb begin
    for (int k = 0; k < PART_GROUPS; k++) begin
      part_next[k] = '0;
      for (int j = 0; j < PART_SIZE; j++) begin
        part_next[k] = part_next[k] + 18'(prod[PART_SIZE*k + j]);
      end
    end
  end

  always_comb begin
    group_sum = '0;
    for (int k = 0; k < PART_GROUPS; k++) begin
      group_sum = group_sum + 20'(part[k]);
    end
    acc_sum = acc + 32'(group_sum);   // wraps at 32 bits
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_prod <= '0;
      ctl_part <= '0;
      acc      <= '0;
      done     <= 1'b0;
    end else begin
      ctl_prod <= ctl_in;
      ctl_part <= ctl_prod;
      done     <= ctl_part.valid && ctl_part.last;
      if (ctl_part.valid) begin
        acc <= ctl_part.last ? '0 : acc_sum;
      end
    end
    for (int i = 0; i < LANES; i++) begin
      prod[i] <= prod_next[i];
    end
    for (int k = 0; k < PART_GROUPS; k++) begin
      part[k] <= part_next[k];
    end
    if (ctl_part.valid && ctl_part.last) begin
      row_sum <= acc_sum;
    end
  end

endmodule

### src/codebook_nibble_dot_product_top.sv
// ---------------------------------------------------------------------------
// codebook_nibble_dot_product_top
// Matrix-vector row product with 4-bit weight codes decoded through a
// 16-entry signed byte codebook against a stored activation vector.
// ---------------------------------------------------------------------------
//
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+----------------------
//  item in   | operation, word_index, payload, last_of_row    | start & !busy
//  result    | row_sum                                        | done, one-cycle strobe
//  config    | cfg_index, cfg_data                            | cfg_write
//
//  One item is taken every cycle; busy stays low.
//  A row sum shows on row_sum with done high once the last weight item of the
//  row has passed the decode/RAM read, products and partial sums registers.
//  Loads write the activation store at the accepting edge; a weight item
//  accepted on the very next cycle already sees that data.
//  rst clears the codebook and the row accumulator; the store is not cleared.
//  The receiver cannot stall: each result is valid for its strobe cycle only.
//
module codebook_nibble_dot_product_top import cnd_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation,
  input  logic [7:0]            word_index,
  input  logic [WORD_W-1:0]     payload,
  input  logic                  last_of_row,
  output logic                  done,
  output logic signed [31:0]    row_sum,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [WORD_W-1:0]     cfg_data
);

  // Store is split into even and odd 64-bit words so a weight item reads
  // both halves of its 16 elements at one address.
  localparam int          BankDepth = (MAX_ELEMENTS + 15) / 16;
  localparam int          BankAw    = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam logic [16:0] WordLimit = 17'((MAX_ELEMENTS + 7) / 8);

  logic              accept;
  logic              load_ok;
  logic              we_even;
  logic              we_odd;
  logic [15:0]       waddr_wide;
  logic [15:0]       raddr_wide;
  logic [BankAw-1:0] waddr;
  logic [BankAw-1:0] raddr;
  logic [WORD_W-1:0] act_even;
  logic [WORD_W-1:0] act_odd;
  logic [WORD_W-1:0] codebook_low;
  logic [WORD_W-1:0] codebook_high;
  stage_ctl_t        dec_ctl;
  lane_bytes_t       dec_entries;
  logic [LANES-1:0]  dec_mask;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign load_ok    = accept && (operation == OP_LOAD) && (17'(word_index) < WordLimit);
  assign we_even    = load_ok && !word_index[0];
  assign we_odd     = load_ok &&  word_index[0];
  assign waddr_wide = {9'b0, word_index[7:1]};
  assign raddr_wide = {8'b0, word_index};
  assign waddr      = waddr_wide[BankAw-1:0];
  assign raddr      = raddr_wide[BankAw-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      codebook_low  <= '0;
      codebook_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CODEBOOK_LOW:  codebook_low  <= cfg_data;
        REG_CODEBOOK_HIGH: codebook_high <= cfg_data;
        default: ;
      endcase
    end
  end

  cnd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BankDepth)
  ) u_ram_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (waddr),
    .wdata (payload),
    .raddr (raddr),
    .rdata (act_even)
  );

  cnd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BankDepth)
  ) u_ram_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (waddr),
    .wdata (payload),
    .raddr (raddr),
    .rdata (act_odd)
  );

  cnd_decode #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_decode (
    .clk           (clk),
    .rst           (rst),
    .weight_valid  (accept && (operation == OP_WEIGHT)),
    .last_of_row   (last_of_row),
    .group         (word_index),
    .payload       (payload),
    .codebook_low  (codebook_low),
    .codebook_high (codebook_high),
    .ctl           (dec_ctl),
    .entries       (dec_entries),
    .act_mask      (dec_mask)
  );

  cnd_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (dec_ctl),
    .entries  (dec_entries),
    .act_mask (dec_mask),
    .act_even (act_even),
    .act_odd  (act_odd),
    .done     (done),
    .row_sum  (row_sum)
  );

endmodule
